// ===== sv/assert_macros.svh =====
// Concurrent assertion helpers, sampled on clk and off during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/xesc_pkg.sv =====
package xesc_pkg;

  localparam int WARN_COUNT_BITS = 32;
  localparam int MaxRes = 9;

  localparam logic [7:0] ChQmark = 8'h3F;
  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChQuot  = 8'h22;
  localparam logic [7:0] ChApos  = 8'h27;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;

  localparam logic [7:0] LeadMin2 = 8'hC2;
  localparam logic [7:0] LeadMin3 = 8'hE0;
  localparam logic [7:0] LeadMin4 = 8'hF0;
  localparam logic [7:0] LeadEnd  = 8'hF5;

  localparam logic [20:0] CpMin3    = 21'h000800;
  localparam logic [20:0] CpMin4    = 21'h010000;
  localparam logic [20:0] CpSurLo   = 21'h00D800;
  localparam logic [20:0] CpSurHi   = 21'h00DFFF;
  localparam logic [20:0] CpMax     = 21'h10FFFF;
  localparam logic [20:0] CpNonFFFE = 21'h00FFFE;
  localparam logic [20:0] CpNonFFFF = 21'h00FFFF;

  // Escape text, first character in txt[5].
  typedef struct packed {
    logic [5:0][7:0] txt;
    logic [2:0]      len;
    logic            rep;
  } esc_t;

  function automatic esc_t esc_lookup(logic [7:0] c);
    esc_t e;
    e.txt = {c, 40'h0};
    e.len = 3'd1;
    e.rep = 1'b0;
    case (c)
      ChAmp:  begin e.txt = {"&amp;", 8'h00};  e.len = 3'd5; end
      ChLt:   begin e.txt = {"&lt;", 16'h0000}; e.len = 3'd4; end
      ChGt:   begin e.txt = {"&gt;", 16'h0000}; e.len = 3'd4; end
      ChQuot: begin e.txt = "&quot;";           e.len = 3'd6; end
      ChApos: begin e.txt = "&apos;";           e.len = 3'd6; end
      ChTab:  begin e.txt = {"&#9;", 16'h0000}; e.len = 3'd4; end
      ChLf:   begin e.txt = {"&#10;", 8'h00};  e.len = 3'd5; end
      ChCr:   begin e.txt = {"&#13;", 8'h00};  e.len = 3'd5; end
      default: begin
        if (c < ChSpace) begin
          e.txt = {ChQmark, 40'h0};
          e.rep = 1'b1;
        end
      end
    endcase
    return e;
  endfunction

  function automatic logic cp_ok(logic [20:0] cp, logic [2:0] need);
    logic ok;
    ok = 1'b1;
    if (need == 3'd3 && cp < CpMin3) ok = 1'b0;
    if (need == 3'd4 && cp < CpMin4) ok = 1'b0;
    if (cp >= CpSurLo && cp <= CpSurHi) ok = 1'b0;
    if (cp > CpMax || cp == CpNonFFFE || cp == CpNonFFFF) ok = 1'b0;
    return ok;
  endfunction

endpackage

// ===== sv/xml_escape_utf8_check.sv =====
// Channel | Handshake          | Word
// in      | in_valid/in_ready  | in_byte, string_end
// out     | out_valid/out_ready| out_byte, run_last, string_last, replaced, warn_count
// cfg     | cfg_wr_en          | cfg_wr_data (utf8_check)
//
// A byte may expand to up to 9 output bytes, held in the expansion buffer and
// sent as a single output byte per cycle while out_ready allows; the next input
// byte enters as the last one leaves. A byte that only extends a held sequence
// produces no output. The path runs through the input register, expansion
// buffer and output register. Synchronous reset, no clearing pass; utf8_check
// resets to 1. Output stalls back up through the buffer to in_ready.
`include "assert_macros.svh"

module xml_escape_utf8_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        string_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        run_last,
  output logic        string_last,
  output logic        replaced,
  output logic [31:0] warn_count
);

  localparam int CntW = xesc_pkg::WARN_COUNT_BITS;
  localparam int NRes = xesc_pkg::MaxRes;

  logic utf8_check;

  // input register
  logic       in_r_valid;
  logic [7:0] in_r_byte;
  logic       in_r_end;

  // sequence state
  logic [7:0]  held_bytes [3];
  logic [1:0]  held_count;
  logic [2:0]  needed_length;
  logic [20:0] partial_cp;

  logic [7:0]  held_next [3];
  logic [1:0]  held_count_next;
  logic [2:0]  needed_length_next;
  logic [20:0] partial_cp_next;

  // expansion buffer, word 0 goes out next
  logic [7:0] seq_byte [NRes];
  logic       seq_rep [NRes];
  logic [3:0] seq_cnt;
  logic       seq_end;

  logic [CntW-1:0] rep_count;
  logic [CntW-1:0] rep_count_next;
  logic [63:0]     rep_wide;

  logic proc;
  logic out_load;

  // per-byte decode
  xesc_pkg::esc_t esc;
  logic [5:0][7:0] fr_txt;
  logic [2:0]  fr_len;
  logic        fr_rep;
  logic        fr_hold;
  logic [2:0]  fr_need;
  logic [20:0] fr_cp;
  logic        cont;
  logic [20:0] cp_new;
  logic [2:0]  pre_len;
  logic        pre_q;
  logic        use_fresh;
  logic [3:0]  fr_idx [NRes];
  logic [7:0]  exp_byte [NRes];
  logic        exp_rep [NRes];
  logic [3:0]  exp_len;

  assign out_load = (seq_cnt != 4'd0) && (!out_valid || out_ready);
  assign proc     = in_r_valid && ((seq_cnt == 4'd0) || (seq_cnt == 4'd1 && out_load));
  assign in_ready = !in_r_valid || proc;

  // Handle a byte with no sequence pending.
  always_comb begin
    esc     = xesc_pkg::esc_lookup(in_r_byte);
    fr_txt  = {in_r_byte, 40'h0};
    fr_len  = 3'd1;
    fr_rep  = 1'b0;
    fr_hold = 1'b0;
    if (in_r_byte < 8'h80) begin
      fr_txt = esc.txt;
      fr_len = esc.len;
      fr_rep = esc.rep;
    end else if (!utf8_check) begin
      fr_len = 3'd1;
    end else if (in_r_byte < xesc_pkg::LeadMin2 || in_r_byte >= xesc_pkg::LeadEnd) begin
      fr_txt = {xesc_pkg::ChQmark, 40'h0};
      fr_rep = 1'b1;
    end else begin
      fr_hold = 1'b1;
      // a lead byte that ends the string flushes as one '?'
      fr_txt  = {xesc_pkg::ChQmark, 40'h0};
      fr_rep  = 1'b1;
      fr_len  = in_r_end ? 3'd1 : 3'd0;
    end
    if (in_r_byte < xesc_pkg::LeadMin3) begin
      fr_need = 3'd2;
      fr_cp   = {16'h0, in_r_byte[4:0]};
    end else if (in_r_byte < xesc_pkg::LeadMin4) begin
      fr_need = 3'd3;
      fr_cp   = {17'h0, in_r_byte[3:0]};
    end else begin
      fr_need = 3'd4;
      fr_cp   = {18'h0, in_r_byte[2:0]};
    end
  end

  // Sequence handling and next state.
  always_comb begin
    cont               = (in_r_byte[7:6] == 2'b10);
    cp_new             = {partial_cp[14:0], in_r_byte[5:0]};
    pre_len            = 3'd0;
    pre_q              = 1'b0;
    use_fresh          = 1'b0;
    held_next          = held_bytes;
    held_count_next    = held_count;
    needed_length_next = needed_length;
    partial_cp_next    = partial_cp;
    if (needed_length == 3'd0) begin
      use_fresh = 1'b1;
    end else if (!utf8_check) begin
      pre_len   = {1'b0, held_count};
      use_fresh = 1'b1;
    end else if (cont) begin
      if ({1'b0, held_count} + 3'd1 >= needed_length) begin
        pre_len            = {1'b0, held_count} + 3'd1;
        pre_q              = !xesc_pkg::cp_ok(cp_new, needed_length);
        held_count_next    = 2'd0;
        needed_length_next = 3'd0;
        partial_cp_next    = '0;
      end else if (in_r_end) begin
        pre_len            = {1'b0, held_count} + 3'd1;
        pre_q              = 1'b1;
        held_count_next    = 2'd0;
        needed_length_next = 3'd0;
        partial_cp_next    = '0;
      end else begin
        for (int k = 0; k < 3; k++) begin
          if (held_count == 2'(k)) held_next[k] = in_r_byte;
        end
        held_count_next = held_count + 2'd1;
        partial_cp_next = cp_new;
      end
    end else begin
      pre_len   = {1'b0, held_count};
      pre_q     = 1'b1;
      use_fresh = 1'b1;
    end
    if (use_fresh) begin
      if (fr_hold && !in_r_end) begin
        held_next[0]       = in_r_byte;
        held_count_next    = 2'd1;
        needed_length_next = fr_need;
        partial_cp_next    = fr_cp;
      end else begin
        held_count_next    = 2'd0;
        needed_length_next = 3'd0;
        partial_cp_next    = '0;
      end
    end
  end

  // Lay out prefix then escape text into one run of words.
  always_comb begin
    exp_len = 4'(pre_len) + (use_fresh ? 4'(fr_len) : 4'd0);
    for (int k = 0; k < NRes; k++) begin
      fr_idx[k]   = 4'(k) - 4'(pre_len);
      exp_byte[k] = xesc_pkg::ChQmark;
      exp_rep[k]  = fr_rep;
      if (4'(k) < 4'(pre_len)) begin
        exp_rep[k] = pre_q;
        if (pre_q) begin
          exp_byte[k] = xesc_pkg::ChQmark;
        end else if (k < 3 && 2'(k) < held_count) begin
          exp_byte[k] = held_bytes[2'(k % 3)];
        end else begin
          exp_byte[k] = in_r_byte;
        end
      end else if (fr_idx[k] < 4'd6) begin
        exp_byte[k] = fr_txt[3'd5 - fr_idx[k][2:0]];
      end
    end
  end

  assign rep_count_next = (seq_rep[0] && rep_count != '1) ? rep_count + CntW'(1) : rep_count;
  assign rep_wide       = 64'(rep_count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      utf8_check    <= 1'b1;
      in_r_valid    <= 1'b0;
      held_count    <= 2'd0;
      needed_length <= 3'd0;
      partial_cp    <= '0;
      seq_cnt       <= 4'd0;
      out_valid     <= 1'b0;
      rep_count     <= '0;
    end else begin
      if (cfg_wr_en) utf8_check <= cfg_wr_data;
      if (in_ready) in_r_valid <= in_valid;
      if (proc) begin
        held_count    <= held_count_next;
        needed_length <= needed_length_next;
        partial_cp    <= partial_cp_next;
        seq_cnt       <= exp_len;
      end else if (out_load) begin
        seq_cnt <= seq_cnt - 4'd1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
        rep_count <= rep_count_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload, no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r_byte <= in_byte;
      in_r_end  <= string_end;
    end
    if (proc) begin
      held_bytes <= held_next;
      seq_byte   <= exp_byte;
      seq_rep    <= exp_rep;
      seq_end    <= in_r_end;
    end else if (out_load) begin
      // advance the run by one word
      for (int k = 0; k < NRes - 1; k++) begin
        seq_byte[k] <= seq_byte[k+1];
        seq_rep[k]  <= seq_rep[k+1];
      end
    end
    if (out_load) begin
      out_byte    <= seq_byte[0];
      replaced    <= seq_rep[0];
      run_last    <= (seq_cnt == 4'd1);
      string_last <= (seq_cnt == 4'd1) && seq_end;
      warn_count  <= (rep_wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rep_wide[31:0];
    end
  end

  `ASSERT_IMPL(a_seq_cnt_range, 1'b1, seq_cnt <= 4'(NRes))
  `ASSERT_IMPL(a_held_pending, 1'b1, (needed_length == 3'd0) == (held_count == 2'd0))
  `ASSERT_IMPL(a_held_short, needed_length != 3'd0, 3'(held_count) < needed_length)
  `ASSERT_IMPL(a_silent_holds, proc && exp_len == 4'd0, needed_length_next != 3'd0)
  `ASSERT_IMPL(a_count_mono, !$past(rst), rep_count >= $past(rep_count))

endmodule

// ===== tb/xesc_stream_checker.sv =====
module xesc_stream_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        string_end,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic        run_last,
  input  logic        string_last,
  input  logic        replaced,
  input  logic [31:0] warn_count,
  output int          pending,
  output int          errors
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] WarnMax = (xesc_pkg::WARN_COUNT_BITS >= 64) ? {64{1'b1}} :
                                    ((64'd1 << xesc_pkg::WARN_COUNT_BITS) - 64'd1);

  typedef struct packed {
    logic [7:0]  ch;
    logic        run_last;
    logic        str_last;
    logic        rep;
    logic [31:0] warn;
  } esc_word_t;

  // predictor state
  logic        utf8_on;
  logic [7:0]  held [3];
  int unsigned n_held;
  int unsigned seq_len;
  logic [20:0] cp_acc;
  logic [63:0] warn_acc;

  esc_word_t   step_words [$];
  esc_word_t   due_words [$];
  int          mismatches;
  int unsigned words_seen;

  task automatic flag_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void emit_word(input logic [7:0] ch, input logic rep);
    esc_word_t w;
    if (step_words.size() >= xesc_pkg::MaxRes) return;
    if (rep && warn_acc < WarnMax) warn_acc++;
    w.ch = ch;
    w.run_last = 1'b0;
    w.str_last = 1'b0;
    w.rep = rep;
    w.warn = (warn_acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : warn_acc[31:0];
    step_words.push_back(w);
  endfunction

  function automatic void emit_text(input string s);
    for (int i = 0; i < s.len(); i++) emit_word(s[i], 1'b0);
  endfunction

  function automatic void clear_held();
    n_held = 0;
    seq_len = 0;
    cp_acc = '0;
    held[0] = '0;
    held[1] = '0;
    held[2] = '0;
  endfunction

  function automatic void flush_held();
    for (int k = 0; k < n_held && k < 3; k++) emit_word(xesc_pkg::ChQmark, 1'b1);
    clear_held();
  endfunction

  function automatic void escape_char(input logic [7:0] c);
    case (c)
      xesc_pkg::ChAmp:   emit_text("&amp;");
      xesc_pkg::ChLt:    emit_text("&lt;");
      xesc_pkg::ChGt:    emit_text("&gt;");
      xesc_pkg::ChQuot:  emit_text("&quot;");
      xesc_pkg::ChApos:  emit_text("&apos;");
      xesc_pkg::ChTab:   emit_text("&#9;");
      xesc_pkg::ChLf:    emit_text("&#10;");
      xesc_pkg::ChCr:    emit_text("&#13;");
      default: begin
        if (c < xesc_pkg::ChSpace) emit_word(xesc_pkg::ChQmark, 1'b1);
        else emit_word(c, 1'b0);
      end
    endcase
  endfunction

  function automatic logic code_point_ok(input logic [20:0] cp, input int unsigned len);
    return !((len == 3 && cp < xesc_pkg::CpMin3) || (len == 4 && cp < xesc_pkg::CpMin4) ||
             (cp >= xesc_pkg::CpSurLo && cp <= xesc_pkg::CpSurHi) ||
             cp > xesc_pkg::CpMax ||
             cp == xesc_pkg::CpNonFFFE || cp == xesc_pkg::CpNonFFFF);
  endfunction

  function automatic void start_fresh(input logic [7:0] c, input logic last);
    if (c < 8'h80) begin
      escape_char(c);
    end else if (!utf8_on) begin
      emit_word(c, 1'b0);
    end else if (c < xesc_pkg::LeadMin2 || c >= xesc_pkg::LeadEnd) begin
      emit_word(xesc_pkg::ChQmark, 1'b1);
    end else begin
      held[0] = c;
      n_held = 1;
      if (c < xesc_pkg::LeadMin3) begin
        seq_len = 2;
        cp_acc = {16'd0, c[4:0]};
      end else if (c < xesc_pkg::LeadMin4) begin
        seq_len = 3;
        cp_acc = {17'd0, c[3:0]};
      end else begin
        seq_len = 4;
        cp_acc = {18'd0, c[2:0]};
      end
      if (last) flush_held();
    end
  endfunction

  // Work out every word one accepted input byte causes and queue them.
  function automatic void take_byte(input logic [7:0] c, input logic last);
    esc_word_t w;
    step_words.delete();
    if (seq_len == 0) begin
      start_fresh(c, last);
    end else if (!utf8_on) begin
      // checking went off while a sequence was held: release it as is
      for (int k = 0; k < n_held && k < 3; k++) emit_word(held[k], 1'b0);
      clear_held();
      start_fresh(c, last);
    end else if (c[7:6] == 2'b10) begin
      cp_acc = {cp_acc[14:0], c[5:0]};
      if (n_held + 1 >= seq_len) begin
        if (code_point_ok(cp_acc, seq_len)) begin
          for (int k = 0; k < n_held && k < 3; k++) emit_word(held[k], 1'b0);
          emit_word(c, 1'b0);
        end else begin
          for (int k = 0; k <= n_held && k < 4; k++) emit_word(xesc_pkg::ChQmark, 1'b1);
        end
        clear_held();
      end else begin
        if (n_held < 3) held[n_held] = c;
        n_held++;
        if (last) flush_held();
      end
    end else begin
      flush_held();
      start_fresh(c, last);
    end
    if (step_words.size() > 0) begin
      w = step_words.pop_back();
      w.run_last = 1'b1;
      w.str_last = last;
      step_words.push_back(w);
    end
    foreach (step_words[i]) due_words.push_back(step_words[i]);
  endfunction

  task automatic check_word();
    esc_word_t w;
    if (due_words.size() == 0) begin
      flag_mismatch($sformatf("word %0d: unexpected %02h", words_seen, out_byte));
    end else begin
      w = due_words.pop_front();
      if (out_byte !== w.ch || run_last !== w.run_last || string_last !== w.str_last ||
          replaced !== w.rep || warn_count !== w.warn)
        flag_mismatch($sformatf(
          "word %0d: got %02h rl=%b sl=%b rep=%b cnt=%0d, want %02h rl=%b sl=%b rep=%b cnt=%0d",
          words_seen, out_byte, run_last, string_last, replaced, warn_count,
          w.ch, w.run_last, w.str_last, w.rep, w.warn));
    end
    words_seen++;
  endtask

  initial begin
    mismatches = 0;
    words_seen = 0;
    pending = 0;
    errors = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      utf8_on = 1'b1;
      clear_held();
      warn_acc = '0;
      due_words.delete();
    end else begin
      if (cfg_wr_en) utf8_on = cfg_wr_data;
      if (in_valid && in_ready) take_byte(in_byte, string_end);
      if (out_valid && out_ready) check_word();
    end
    pending <= due_words.size();
    errors <= mismatches;
  end

endmodule

// ===== tb/tb_xml_escape_utf8_check.sv =====
module tb_xml_escape_utf8_check;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 200000;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        string_end;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        run_last;
  logic        string_last;
  logic        replaced;
  logic [31:0] warn_count;

  int          pending;
  int          errors;
  int          cycles;
  int          idle_pct;
  int unsigned stall_left;
  logic [7:0]  byte_pool [$];

  xml_escape_utf8_check uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .string_end  (string_end),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .run_last    (run_last),
    .string_last (string_last),
    .replaced    (replaced),
    .warn_count  (warn_count)
  );

  xesc_stream_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .string_end  (string_end),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .run_last    (run_last),
    .string_last (string_last),
    .replaced    (replaced),
    .warn_count  (warn_count),
    .pending     (pending),
    .errors      (errors)
  );

  initial begin
    clk = 1'b0;
    cycles = 0;
  end

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: drop out_ready in bursts while idling is on.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 4) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    string_end <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Hold until every expected word is out, then let a held byte settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_utf8_check(input logic v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic void push_char(input int unsigned cp, input int unsigned n,
                                    input int unsigned keep);
    int unsigned lead;
    if (n == 2) lead = 'hC0 | ((cp >> 6) & 'h1F);
    else if (n == 3) lead = 'hE0 | ((cp >> 12) & 'h0F);
    else lead = 'hF0 | ((cp >> 18) & 'h07);
    byte_pool.push_back(lead[7:0]);
    for (int unsigned i = 1; i < keep; i++)
      byte_pool.push_back(8'h80 | 8'((cp >> (6 * (n - 1 - i))) & 'h3F));
  endfunction

  function automatic int unsigned pick_edge_cp();
    case ($urandom_range(0, 13))
      0:       return 'h80;
      1:       return 'h7FF;
      2:       return 'h800;
      3:       return 'hD7FF;
      4:       return 'hD800;
      5:       return 'hDFFF;
      6:       return 'hE000;
      7:       return 'hFFFD;
      8:       return 'hFFFE;
      9:       return 'hFFFF;
      10:      return 'h10000;
      11:      return 'h10FFFF;
      12:      return 'h110000;
      default: return 'h1FFFFF;
    endcase
  endfunction

  function automatic logic [7:0] pick_ascii();
    case ($urandom_range(0, 13))
      4:       return 8'($urandom_range(0, 'h1F));
      5:       return xesc_pkg::ChAmp;
      6:       return xesc_pkg::ChLt;
      7:       return xesc_pkg::ChGt;
      8:       return xesc_pkg::ChQuot;
      9:       return xesc_pkg::ChApos;
      10:      return xesc_pkg::ChTab;
      11:      return xesc_pkg::ChLf;
      12:      return xesc_pkg::ChCr;
      13:      return 8'h7F;
      default: return 8'($urandom_range('h20, 'h7E));
    endcase
  endfunction

  // Encoded characters, whole or cut short, some overlong; the rest ASCII, stray bytes or noise.
  function automatic void make_token();
    int unsigned cp;
    int unsigned n;
    int unsigned sel;
    case ($urandom_range(0, 4))
      0:       cp = pick_edge_cp();
      1:       cp = $urandom_range('h80, 'h7FF);
      2:       cp = $urandom_range('h800, 'hFFFF);
      3:       cp = $urandom_range('h10000, 'h10FFFF);
      default: cp = $urandom_range(0, 'h7F);
    endcase
    if (cp < 'h80) n = $urandom_range(2, 4);
    else if (cp < 'h800) n = 2;
    else if (cp < 'h10000) n = 3;
    else n = 4;
    if (n < 4 && cp >= 'h80 && $urandom_range(0, 9) == 0) n++;
    sel = $urandom_range(0, 99);
    if (sel < 45) push_char(cp, n, n);
    else if (sel < 58) push_char(cp, n, $urandom_range(1, n - 1));
    else if (sel < 80) byte_pool.push_back(pick_ascii());
    else if (sel < 90) byte_pool.push_back(8'($urandom_range(0, 255)));
    else if (sel < 95) byte_pool.push_back(8'($urandom_range('h80, 'hBF)));
    else byte_pool.push_back(8'($urandom_range('hF5, 'hFF)));
  endfunction

  task automatic run_phase(input int unsigned n_items, input logic vary_idle);
    for (int unsigned i = 0; i < n_items; i++) begin
      if (vary_idle && i % 40 == 0) idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
      if (byte_pool.size() == 0) make_token();
      send_byte(byte_pool.pop_front(), $urandom_range(0, 11) == 0);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    in_valid = 1'b0;
    in_byte = '0;
    string_end = 1'b0;
    idle_pct = 30;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // escapes and plain ASCII, checking on from reset
    send_byte(8'h00, 1'b0);
    send_byte(xesc_pkg::ChTab, 1'b0);
    send_byte(xesc_pkg::ChLf, 1'b0);
    send_byte(xesc_pkg::ChCr, 1'b0);
    send_byte(xesc_pkg::ChAmp, 1'b0);
    send_byte(xesc_pkg::ChLt, 1'b0);
    send_byte(xesc_pkg::ChGt, 1'b0);
    send_byte(xesc_pkg::ChQuot, 1'b0);
    send_byte(xesc_pkg::ChApos, 1'b0);
    send_byte(8'h7F, 1'b1);
    // stray lead
    send_byte(8'hFF, 1'b0);
    // well-formed two-byte character
    send_byte(8'hC2, 1'b0);
    send_byte(8'h80, 1'b1);
    // overlong three-byte form
    send_byte(8'hE0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    // sequence broken by ASCII
    send_byte(8'hE4, 1'b0);
    send_byte(8'h41, 1'b0);
    // three held bytes broken by a quote: the widest expansion
    send_byte(8'hF0, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(xesc_pkg::ChQuot, 1'b1);
    // unfinished at string end, and a lead that ends the string
    send_byte(8'hF0, 1'b0);
    send_byte(8'h90, 1'b1);
    send_byte(8'hC3, 1'b1);

    // drop checking while a sequence is held
    send_byte(8'hE4, 1'b0);
    send_byte(8'h80, 1'b0);
    wait_drained();
    write_utf8_check(1'b0);
    send_byte(8'h41, 1'b1);

    run_phase(80, 1'b1);
    wait_drained();
    write_utf8_check(1'b1);
    run_phase(100, 1'b1);
    wait_drained();
    write_utf8_check(1'b0);
    run_phase(40, 1'b1);
    wait_drained();
    write_utf8_check(1'b1);
    run_phase(40, 1'b1);
    idle_pct = 0;
    run_phase(60, 1'b0);

    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
